/* rtl/lcg_pkg.sv */
`timescale 1ns / 1ps

package lcg_pkg;

  // bitmap depth and widths fixed by the value range
  localparam int MAX_MOD = 16384;
  localparam int ADDR_W  = $clog2(MAX_MOD);
  localparam int VAL_W   = 14;
  localparam int CNT_W   = 15;
  localparam int MOD_W   = 15;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = PROD_W + 1;
  // dividend padded to an even width, two quotient bits per cycle
  localparam int DVD_W     = SUM_W + (SUM_W % 2);
  localparam int MOD_ITERS = DVD_W / 2;
  localparam int ITER_W    = $clog2(MOD_ITERS);

  localparam logic [VAL_W-1:0] MULT_RST = 14'd2061;
  localparam logic [VAL_W-1:0] INC_RST  = 14'd4321;
  localparam logic [MOD_W-1:0] MOD_RST  = 15'd10000;
  localparam logic [MOD_W-1:0] MOD_CAP  = MOD_W'(MAX_MOD);

  typedef enum logic [1:0] {
    REG_MULTIPLIER = 2'd0,
    REG_INCREMENT  = 2'd1,
    REG_MODULUS    = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CLEAR,
    S_READ,
    S_CHECK,
    S_MOD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [MOD_W-1:0] modulus;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] rem;
  } mod_rsp_t;

endpackage

/* rtl/lcg_mod.sv */
`timescale 1ns / 1ps

module lcg_mod (
  input  logic              clk,
  input  logic              rst,
  input  lcg_pkg::mod_req_t req,
  output lcg_pkg::mod_rsp_t rsp
);

  logic                               busy;
  logic                               done;
  logic [lcg_pkg::ITER_W-1:0]         iter;
  logic [lcg_pkg::DVD_W-1:0]          dvd;
  logic [lcg_pkg::MOD_W-1:0]          m;
  logic [lcg_pkg::VAL_W-1:0]          rem;
  logic [lcg_pkg::MOD_W-1:0]          t1;
  logic [lcg_pkg::MOD_W-1:0]          t2;
  logic [lcg_pkg::VAL_W-1:0]          r1;
  logic [lcg_pkg::VAL_W-1:0]          r2;

  // two restoring steps per cycle, remainder always below m
  always_comb begin
    t1 = {rem, dvd[lcg_pkg::DVD_W-1]};
    r1 = (t1 >= m) ? lcg_pkg::VAL_W'(t1 - m) : lcg_pkg::VAL_W'(t1);
    t2 = {r1, dvd[lcg_pkg::DVD_W-2]};
    r2 = (t2 >= m) ? lcg_pkg::VAL_W'(t2 - m) : lcg_pkg::VAL_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == lcg_pkg::ITER_W'(lcg_pkg::MOD_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      m   <= req.modulus;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[lcg_pkg::DVD_W-3:0], 2'b00};
      rem <= r2;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("modulo unit restarted while busy");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("modulo unit not busy after start");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, rem} < m))
    else $error("remainder not below modulus");
`endif

endmodule

/* rtl/lcg_period_finder.sv */
`timescale 1ns / 1ps

// Period search for x = (multiplier*x + increment) mod modulus. Each request
// carries a seed; the block clears its 16384-entry visited bitmap (one entry
// per cycle), then steps the generator until a value repeats and returns the
// count of distinct values and the repeated value. A step is a bitmap read,
// a check that marks the value and starts the modulo of the product plus
// increment, and a wait on the modulo unit, which retires two remainder bits
// per cycle. A seed not below the modulus returns seed_error without touching
// the bitmap; a modulus above 16384 is treated as 16384. in_stall is high for
// the whole run, and a finished result waits in the output register while the
// next request is taken.
module lcg_period_finder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [lcg_pkg::MOD_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lcg_pkg::VAL_W-1:0]   seed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lcg_pkg::CNT_W-1:0]   distinct_count,
  output logic [lcg_pkg::VAL_W-1:0]   repeat_value,
  output logic                        seed_error
);

  lcg_pkg::state_t               state;
  lcg_pkg::state_t               state_next;
  logic [lcg_pkg::VAL_W-1:0]     multiplier;
  logic [lcg_pkg::VAL_W-1:0]     increment;
  logic [lcg_pkg::MOD_W-1:0]     modulus;
  logic [lcg_pkg::MOD_W-1:0]     m_eff;
  logic [lcg_pkg::VAL_W-1:0]     x;
  logic [lcg_pkg::VAL_W-1:0]     x_next;
  logic [lcg_pkg::CNT_W-1:0]     count;
  logic [lcg_pkg::CNT_W-1:0]     count_next;
  logic [lcg_pkg::ADDR_W-1:0]    clr;
  logic [lcg_pkg::ADDR_W-1:0]    clr_next;
  logic                          err;
  logic                          err_next;
  logic                          load_out;

  logic                          map_mem [lcg_pkg::MAX_MOD];
  logic                          map_we;
  logic                          map_wdata;
  logic [lcg_pkg::ADDR_W-1:0]    map_addr;
  logic                          map_rd;

  logic [lcg_pkg::PROD_W-1:0]    prod;
  logic [lcg_pkg::SUM_W-1:0]     sum;
  lcg_pkg::mod_req_t             mod_req;
  lcg_pkg::mod_rsp_t             mod_rsp;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= lcg_pkg::MULT_RST;
      increment  <= lcg_pkg::INC_RST;
      modulus    <= lcg_pkg::MOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcg_pkg::REG_MULTIPLIER: multiplier <= cfg_data[lcg_pkg::VAL_W-1:0];
        lcg_pkg::REG_INCREMENT:  increment  <= cfg_data[lcg_pkg::VAL_W-1:0];
        lcg_pkg::REG_MODULUS:    modulus    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m_eff = (modulus > lcg_pkg::MOD_CAP) ? lcg_pkg::MOD_CAP : modulus;

  assign prod = multiplier * x;
  assign sum  = {1'b0, prod} + {{(lcg_pkg::SUM_W - lcg_pkg::VAL_W){1'b0}}, increment};

  // visited bitmap, one port
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= map_wdata;
    end
    map_rd <= map_mem[map_addr];
  end

  lcg_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcg_pkg::S_IDLE;
      x     <= '0;
      count <= '0;
      clr   <= '0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      x     <= x_next;
      count <= count_next;
      clr   <= clr_next;
      err   <= err_next;
    end
  end

  always_comb begin
    state_next       = state;
    x_next           = x;
    count_next       = count;
    clr_next         = clr;
    err_next         = err;
    load_out         = 1'b0;
    map_we           = 1'b0;
    map_wdata        = 1'b0;
    map_addr         = x;
    mod_req.start    = 1'b0;
    mod_req.dividend = {{(lcg_pkg::DVD_W - lcg_pkg::SUM_W){1'b0}}, sum};
    mod_req.modulus  = m_eff;
    in_stall         = (state != lcg_pkg::S_IDLE);
    unique case (state)
      lcg_pkg::S_IDLE: begin
        if (in_valid) begin
          x_next     = seed;
          state_next = lcg_pkg::S_START;
        end
      end
      lcg_pkg::S_START: begin
        if ({1'b0, x} >= m_eff) begin
          err_next   = 1'b1;
          state_next = lcg_pkg::S_DONE;
        end else begin
          err_next   = 1'b0;
          count_next = '0;
          clr_next   = '0;
          state_next = lcg_pkg::S_CLEAR;
        end
      end
      lcg_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_addr  = clr;
        map_wdata = 1'b0;
        clr_next  = clr + 1'b1;
        if (clr == '1) begin
          state_next = lcg_pkg::S_READ;
        end
      end
      lcg_pkg::S_READ: begin
        state_next = lcg_pkg::S_CHECK;
      end
      lcg_pkg::S_CHECK: begin
        if (map_rd) begin
          state_next = lcg_pkg::S_DONE;
        end else begin
          map_we        = 1'b1;
          map_wdata     = 1'b1;
          count_next    = count + 1'b1;
          mod_req.start = 1'b1;
          state_next    = lcg_pkg::S_MOD;
        end
      end
      lcg_pkg::S_MOD: begin
        if (mod_rsp.done) begin
          x_next     = mod_rsp.rem;
          state_next = lcg_pkg::S_READ;
        end
      end
      lcg_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = lcg_pkg::S_IDLE;
        end
      end
      default: state_next = lcg_pkg::S_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      distinct_count <= err ? '0 : count;
      repeat_value   <= err ? '0 : x;
      seed_error     <= err;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == lcg_pkg::S_START))
    else $error("accepted request did not start a run");
  a_load_valid: assert property (@(posedge clk) disable iff (rst) load_out |=> out_valid)
    else $error("result loaded but not valid");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= lcg_pkg::CNT_W'(lcg_pkg::MAX_MOD))
    else $error("distinct count beyond bitmap depth");
`endif

endmodule
